### rtl/cawl_pkg.sv
package cawl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int UID_BYTES   = 7;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int UID_W       = 56;
  localparam int LEN_W       = 3;
  localparam int TICKS_W     = 16;
  localparam int ELAPSED_W   = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = UID_W;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0]   MGR_LEN_RST = 3'd4;
  localparam logic [TICKS_W-1:0] UNLOCK_RST  = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MANAGER_UID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MANAGER_UID_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_TICKS    = 2'd2;

  // Transaction opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ARMED   = 3'd1,
    EV_ADDED   = 3'd2,
    EV_NO_ADD  = 3'd3,
    EV_GRANTED = 3'd4,
    EV_DENIED  = 3'd5,
    EV_CLOSED  = 3'd6
  } event_t;

  typedef struct packed {
    logic             opcode;
    logic [UID_W-1:0] card_uid;
    logic [LEN_W-1:0] uid_len;
  } cawl_in_t;

  typedef struct packed {
    logic             lock_drive;
    event_t           event_res;
    logic [CNT_W-1:0] entries_used;
  } cawl_out_t;

  typedef struct packed {
    logic [UID_W-1:0]   manager_uid;
    logic [LEN_W-1:0]   manager_len;
    logic [TICKS_W-1:0] unlock_ticks;
  } cawl_cfg_t;

  // One whitelist entry: normalised length and UID
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [UID_W-1:0] uid;
  } entry_t;

  // Keep only the valid low bytes of a UID
  function automatic logic [UID_W-1:0] uid_mask(input logic [UID_W-1:0] v,
                                                input logic [LEN_W-1:0] n);
    logic [UID_W-1:0] m;
    m = '0;
    for (int b = 0; b < UID_BYTES; b++) begin
      if (b < int'(n)) begin
        m[b*8 +: 8] = v[b*8 +: 8];
      end
    end
    return m;
  endfunction

  // Clamp a length to the supported UID size
  function automatic logic [LEN_W-1:0] len_norm(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (int'(n) > UID_BYTES) begin
      r = LEN_W'(UID_BYTES);
    end
    return r;
  endfunction

  // Build the comparison key of a UID
  function automatic entry_t make_key(input logic [UID_W-1:0] v,
                                      input logic [LEN_W-1:0] n);
    entry_t k;
    k.len = len_norm(n);
    k.uid = uid_mask(v, k.len);
    return k;
  endfunction

endpackage

### rtl/cawl_table.sv
module cawl_table (
  input  logic                        clk,
  input  logic                        we,
  input  logic [cawl_pkg::ADDR_W-1:0] waddr,
  input  cawl_pkg::entry_t            wdata,
  input  logic [cawl_pkg::ADDR_W-1:0] raddr,
  output cawl_pkg::entry_t            rdata
);

  cawl_pkg::entry_t mem [cawl_pkg::TABLE_DEPTH];

  // Write the enrolled entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/cawl_seq.sv
module cawl_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  cawl_pkg::cawl_in_t          cmd,
  input  cawl_pkg::cawl_cfg_t         cfg,
  output logic                        busy,
  output logic                        done,
  output cawl_pkg::cawl_out_t         res,
  output logic                        tbl_we,
  output logic [cawl_pkg::ADDR_W-1:0] tbl_waddr,
  output cawl_pkg::entry_t            tbl_wdata,
  output logic [cawl_pkg::ADDR_W-1:0] tbl_raddr,
  input  cawl_pkg::entry_t            tbl_rdata
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CHECK  = 3'b010,
    S_SEARCH = 3'b100
  } state_t;

  state_t                               state;
  state_t                               state_next;
  logic                                 is_tick;
  cawl_pkg::entry_t                     key;
  logic [cawl_pkg::CNT_W-1:0]           idx;
  logic                                 cmp_valid;
  logic                                 cmp_last;
  logic [cawl_pkg::CNT_W-1:0]           count;
  logic [cawl_pkg::CNT_W-1:0]           count_next;
  logic                                 armed;
  logic                                 armed_next;
  logic                                 door;
  logic                                 door_next;
  logic [cawl_pkg::ELAPSED_W-1:0]       elapsed;
  logic [cawl_pkg::ELAPSED_W-1:0]       elapsed_next;
  logic [cawl_pkg::ELAPSED_W-1:0]       elapsed_inc;
  cawl_pkg::event_t                     ev;
  cawl_pkg::entry_t                     mgr_key;
  logic                                 is_mgr;
  logic                                 hit;
  logic                                 issue;
  logic                                 resolve;
  logic                                 found;
  logic                                 table_full;
  logic                                 accept;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);

  // Two compare units: key against manager and against the table entry read back
  assign mgr_key   = cawl_pkg::make_key(cfg.manager_uid, cfg.manager_len);
  assign is_mgr    = (key == mgr_key);
  assign hit       = cmp_valid && (tbl_rdata == key);

  assign issue     = (idx < count);
  assign tbl_raddr = idx[cawl_pkg::ADDR_W-1:0];
  assign tbl_waddr = count[cawl_pkg::ADDR_W-1:0];
  assign tbl_wdata = key;

  assign table_full  = (count == cawl_pkg::CNT_W'(cawl_pkg::TABLE_DEPTH));
  assign elapsed_inc = (elapsed == cawl_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;

  // Decide when the transaction is finished
  always_comb begin
    resolve    = 1'b0;
    found      = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        resolve = is_tick || is_mgr || (count == '0);
        if (resolve) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        found   = hit;
        resolve = hit || (cmp_valid && cmp_last);
        if (resolve) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Work out the outcome of the finished transaction
  always_comb begin
    count_next   = count;
    armed_next   = armed;
    door_next    = door;
    elapsed_next = elapsed;
    ev           = cawl_pkg::EV_NONE;
    tbl_we       = 1'b0;
    if (is_tick) begin
      if (door) begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc > {1'b0, cfg.unlock_ticks}) begin
          door_next = 1'b0;
          ev        = cawl_pkg::EV_CLOSED;
        end
      end
    end else if (is_mgr) begin
      armed_next = 1'b1;
      ev         = cawl_pkg::EV_ARMED;
    end else if (armed) begin
      armed_next = 1'b0;
      if (!found && !table_full) begin
        tbl_we     = resolve;
        count_next = count + 1'b1;
        ev         = cawl_pkg::EV_ADDED;
      end else begin
        ev = cawl_pkg::EV_NO_ADD;
      end
    end else if (found) begin
      door_next    = 1'b1;
      elapsed_next = '0;
      ev           = cawl_pkg::EV_GRANTED;
    end else begin
      ev = cawl_pkg::EV_DENIED;
    end
  end

  // Advance the sequencer and commit state on resolve
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      armed     <= 1'b0;
      door      <= 1'b0;
      elapsed   <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      done  <= resolve;
      if (resolve) begin
        count   <= count_next;
        armed   <= armed_next;
        door    <= door_next;
        elapsed <= elapsed_next;
      end
      if (state == S_SEARCH) begin
        cmp_valid <= issue;
        cmp_last  <= (idx == count - 1'b1);
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end else begin
        cmp_valid <= 1'b0;
        cmp_last  <= 1'b0;
        idx       <= '0;
      end
    end
  end

  // Hold the transaction key
  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick <= (cmd.opcode == cawl_pkg::OP_TICK);
      key     <= cawl_pkg::make_key(cmd.card_uid, cmd.uid_len);
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (resolve) begin
      res.lock_drive   <= door_next;
      res.event_res    <= ev;
      res.entries_used <= count_next;
    end
  end

endmodule

### rtl/card_access_whitelist_with_enroll.sv
// Card access whitelist with enroll mode.
// Command channel: present cmd with start high; the command is taken at a
// rising edge where start is high and busy is low. A command is either one
// card scan (UID and length) or one timer tick.
// Result channel: done is high for exactly one cycle with res valid; the
// receiver cannot stall and must take it in that cycle.
// Search: a tick, a manager card or a scan against an empty table is
// resolved in the check state. Any other scan walks the whitelist one
// entry per cycle through the table memory read port and the table entry
// comparator, stopping early on a match. busy stays high until the result
// is out; one command at a time, so no new command is taken before then.
// Configuration: cfg_we writes cfg_data into register cfg_idx (0 manager
// UID, 1 manager UID length, 2 unlock ticks). The user must write only
// while idle; the block itself does not enforce this.
// Reset: the whitelist is emptied (fill count to zero), enroll mode and the
// lock are cleared, and the registers return to manager UID 0, length 4
// and 1000 unlock ticks. The table memory itself needs no clearing pass.
module card_access_whitelist_with_enroll (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  cawl_pkg::cawl_in_t              cmd,
  output logic                            busy,
  output logic                            done,
  output cawl_pkg::cawl_out_t             res,
  input  logic                            cfg_we,
  input  logic [cawl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cawl_pkg::CFG_DATA_W-1:0] cfg_data
);

  cawl_pkg::cawl_cfg_t           cfg;
  logic                          tbl_we;
  logic [cawl_pkg::ADDR_W-1:0]   tbl_waddr;
  cawl_pkg::entry_t              tbl_wdata;
  logic [cawl_pkg::ADDR_W-1:0]   tbl_raddr;
  cawl_pkg::entry_t              tbl_rdata;

  // Write the configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.manager_uid  <= '0;
      cfg.manager_len  <= cawl_pkg::MGR_LEN_RST;
      cfg.unlock_ticks <= cawl_pkg::UNLOCK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cawl_pkg::CFG_MANAGER_UID: begin
          cfg.manager_uid <= cfg_data[cawl_pkg::UID_W-1:0];
        end
        cawl_pkg::CFG_MANAGER_UID_LEN: begin
          cfg.manager_len <= cfg_data[cawl_pkg::LEN_W-1:0];
        end
        cawl_pkg::CFG_UNLOCK_TICKS: begin
          cfg.unlock_ticks <= cfg_data[cawl_pkg::TICKS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  cawl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg       (cfg),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata)
  );

  cawl_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> res.entries_used <= cawl_pkg::CNT_W'(cawl_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_grant_opens: assert property (@(posedge clk) disable iff (rst)
    done && res.event_res == cawl_pkg::EV_GRANTED |-> res.lock_drive)
    else $error("grant reported with lock closed");
`endif

endmodule

### dv/card_access_whitelist_with_enroll_tb.sv
`timescale 1ns / 100ps

module card_access_whitelist_with_enroll_tb;
  import cawl_pkg::*;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  start;
  cawl_in_t              cmd;
  logic                  busy;
  logic                  done;
  cawl_out_t             res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  card_access_whitelist_with_enroll dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Predicted register contents
  logic [UID_W-1:0]   mgr_uid_r  = '0;
  logic [LEN_W-1:0]   mgr_len_r  = MGR_LEN_RST;
  logic [TICKS_W-1:0] hold_ticks = UNLOCK_RST;

  // Predicted door and whitelist state
  logic [UID_W-1:0]     roster_uid [TABLE_DEPTH];
  logic [LEN_W-1:0]     roster_len [TABLE_DEPTH];
  int                   roster_fill = 0;
  bit                   enroll_open = 1'b0;
  bit                   door_open   = 1'b0;
  logic [ELAPSED_W-1:0] open_ticks  = '0;

  cawl_out_t pending_outcomes [$];
  cawl_out_t want;
  int        fail_count      = 0;
  int        commands_sent   = 0;
  int        results_checked = 0;
  int        directed_count  = 0;
  int        event_tally [7] = '{default: 0};
  bit        quiet           = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("card_access_whitelist_with_enroll_tb: FAIL");
    $finish;
  end

  // Bytes of a UID that take part in a comparison
  function automatic logic [UID_W-1:0] valid_bytes_mask(input logic [LEN_W-1:0] n);
    return UID_W'((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic logic [UID_W-1:0] random_uid();
    return UID_W'({$urandom, $urandom});
  endfunction

  function automatic bit on_roster(input logic [UID_W-1:0] v, input logic [LEN_W-1:0] n);
    for (int i = 0; i < roster_fill; i++) begin
      if (roster_len[i] == n && roster_uid[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the door model by one transaction and return what it reports
  function automatic cawl_out_t lock_outcome(input cawl_in_t t);
    cawl_out_t        o;
    event_t           ev;
    logic [LEN_W-1:0] n;
    logic [UID_W-1:0] v;
    logic [UID_W-1:0] mv;
    ev = EV_NONE;
    if (t.opcode == OP_TICK) begin
      if (door_open) begin
        if (open_ticks != ELAPSED_MAX) open_ticks = open_ticks + 1'b1;
        if (open_ticks > ELAPSED_W'(hold_ticks)) begin
          door_open = 1'b0;
          ev = EV_CLOSED;
        end
      end
    end else begin
      n  = t.uid_len;
      v  = t.card_uid & valid_bytes_mask(n);
      mv = mgr_uid_r & valid_bytes_mask(mgr_len_r);
      if (n == mgr_len_r && v == mv) begin
        enroll_open = 1'b1;
        ev = EV_ARMED;
      end else if (enroll_open) begin
        if (!on_roster(v, n) && roster_fill < TABLE_DEPTH) begin
          roster_uid[roster_fill] = v;
          roster_len[roster_fill] = n;
          roster_fill++;
          ev = EV_ADDED;
        end else begin
          ev = EV_NO_ADD;
        end
        enroll_open = 1'b0;
      end else if (on_roster(v, n)) begin
        door_open  = 1'b1;
        open_ticks = '0;
        ev = EV_GRANTED;
      end else begin
        ev = EV_DENIED;
      end
    end
    event_tally[int'(ev)]++;
    o.lock_drive   = door_open;
    o.event_res    = ev;
    o.entries_used = CNT_W'(roster_fill);
    return o;
  endfunction

  // Card scan, optionally with junk above the valid bytes
  function automatic cawl_in_t scan_item(input logic [UID_W-1:0] v,
                                         input logic [LEN_W-1:0] n, input bit dirty);
    cawl_in_t         t;
    logic [UID_W-1:0] keep;
    keep       = valid_bytes_mask(n);
    t.opcode   = OP_SCAN;
    t.uid_len  = n;
    t.card_uid = (v & keep) | (dirty ? (random_uid() & ~keep) : '0);
    return t;
  endfunction

  // Tick with random content in the unused fields
  function automatic cawl_in_t tick_item();
    cawl_in_t t;
    t.opcode   = OP_TICK;
    t.card_uid = random_uid();
    t.uid_len  = LEN_W'($urandom_range(0, 7));
    return t;
  endfunction

  // Mostly back to back, sometimes short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      results_checked++;
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result with no transaction outstanding", $time);
      end else begin
        want = pending_outcomes.pop_front();
        if (res.lock_drive !== want.lock_drive || res.event_res !== want.event_res ||
            res.entries_used !== want.entries_used) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch: expected lock %0b event %0d entries %0d, got %0b %0d %0d",
                     $time, want.lock_drive, want.event_res, want.entries_used,
                     res.lock_drive, res.event_res, res.entries_used);
        end
      end
    end
  end

  // Hand one transaction over, predict it, then idle for a random gap, maybe none
  task automatic issue_command(input cawl_in_t t);
    int gap;
    cmd   <= t;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_outcomes.push_back(lock_outcome(t));
    commands_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_for_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0 || busy !== 1'b0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_MANAGER_UID:     mgr_uid_r  = data[UID_W-1:0];
      CFG_MANAGER_UID_LEN: mgr_len_r  = data[LEN_W-1:0];
      CFG_UNLOCK_TICKS:    hold_ticks = data[TICKS_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset settings: manager is UID zero of four bytes
  task automatic test_reset_defaults();
    issue_command(scan_item('0, 3'd4, 1'b0));
    issue_command(scan_item(56'h12345678, 3'd4, 1'b1));
    issue_command(tick_item());
    issue_command(scan_item(56'h12345678, 3'd4, 1'b0));
    issue_command(scan_item(56'h12345678, 3'd3, 1'b0));
  endtask

  // Write each register, junk above the narrow ones, and the spare index
  task automatic test_config_registers();
    wait_for_quiet();
    write_reg(CFG_MANAGER_UID, 56'hFF_EE_DD_A5_5A_C3_3C);
    write_reg(CFG_MANAGER_UID_LEN, {53'h1F_0F0F_0F0F_0F0F, 3'd4});
    write_reg(CFG_UNLOCK_TICKS, {40'hFF_FFFF_FFFF, 16'd2});
    write_reg(CFG_SPARE, '1);
    issue_command(scan_item(56'hA55AC33C, 3'd4, 1'b1));
  endtask

  task automatic test_enroll_cases();
    // Manager again while armed, then same bytes at another length
    issue_command(scan_item(56'hA55AC33C, 3'd4, 1'b1));
    issue_command(scan_item(56'hA55AC33C, 3'd5, 1'b0));
    // Empty UID: enrol it, then refuse it as already present
    issue_command(scan_item(56'hA55AC33C, 3'd4, 1'b0));
    issue_command(scan_item('0, 3'd0, 1'b1));
    issue_command(scan_item(56'hA55AC33C, 3'd4, 1'b0));
    issue_command(scan_item('0, 3'd0, 1'b1));
    // Grant, grant again while open, then run the timer out
    issue_command(scan_item(56'hA55AC33C, 3'd5, 1'b0));
    issue_command(tick_item());
    issue_command(scan_item('1, 3'd0, 1'b0));
    repeat (4) issue_command(tick_item());
    // Unknown cards at both ends of the field range
    issue_command(scan_item('1, 3'd7, 1'b0));
    issue_command(scan_item('0, 3'd1, 1'b0));
  endtask

  // Mixed traffic under one setting of the registers
  task automatic test_random_traffic(input int n_items, input logic [UID_W-1:0] muid,
                                     input logic [LEN_W-1:0] mlen,
                                     input logic [TICKS_W-1:0] ticks);
    logic [CFG_DATA_W-1:0] junk;
    logic [UID_W-1:0]      v;
    logic [LEN_W-1:0]      n;
    int                    pick;
    int                    idx;
    wait_for_quiet();
    write_reg(CFG_MANAGER_UID, muid);
    junk = random_uid();
    junk[LEN_W-1:0] = mlen;
    write_reg(CFG_MANAGER_UID_LEN, junk);
    junk = random_uid();
    junk[TICKS_W-1:0] = ticks;
    write_reg(CFG_UNLOCK_TICKS, junk);
    for (int i = 0; i < n_items; i++) begin
      quiet = ((i / 40) % 3 == 2);
      if (i == n_items / 2) wait_for_quiet();
      pick = $urandom_range(0, 99);
      idx  = (roster_fill > 0) ? $urandom_range(0, roster_fill - 1) : 0;
      if (enroll_open && pick < 65) begin
        // Finish the enrol sequence, now and then with a card already listed
        if (pick < 12 && roster_fill > 0)
          issue_command(scan_item(roster_uid[idx], roster_len[idx],
                                  1'($urandom_range(0, 1))));
        else
          issue_command(scan_item(random_uid(), LEN_W'($urandom_range(1, 7)),
                                  1'($urandom_range(0, 1))));
      end else if (pick < 5) begin
        issue_command(scan_item(mgr_uid_r, mgr_len_r, 1'($urandom_range(0, 1))));
      end else if (pick < 30 && roster_fill > 0) begin
        issue_command(scan_item(roster_uid[idx], roster_len[idx],
                                1'($urandom_range(0, 1))));
      end else if (pick < 36 && roster_fill > 0 && roster_len[idx] != 0) begin
        // Near miss: one valid bit flipped
        v = roster_uid[idx];
        n = roster_len[idx];
        pick = $urandom_range(0, 8 * n - 1);
        v[pick] = ~v[pick];
        issue_command(scan_item(v, n, 1'($urandom_range(0, 1))));
      end else if (pick < 50) begin
        issue_command(scan_item(random_uid(), LEN_W'($urandom_range(0, 7)),
                                1'($urandom_range(0, 1))));
      end else begin
        issue_command(tick_item());
      end
    end
    quiet = 1'b0;
  endtask

  // Enrol until the table is full, then probe refusals and deep lookups
  task automatic test_fill_table();
    wait_for_quiet();
    while (roster_fill < TABLE_DEPTH) begin
      issue_command(scan_item(mgr_uid_r, mgr_len_r, 1'($urandom_range(0, 1))));
      issue_command(scan_item(random_uid(), LEN_W'($urandom_range(1, 7)),
                              1'($urandom_range(0, 1))));
    end
    issue_command(scan_item(mgr_uid_r, mgr_len_r, 1'b0));
    issue_command(scan_item(random_uid(), 3'd7, 1'b0));
    issue_command(scan_item(mgr_uid_r, mgr_len_r, 1'b0));
    issue_command(scan_item(roster_uid[0], roster_len[0], 1'b1));
    issue_command(scan_item(roster_uid[TABLE_DEPTH-1], roster_len[TABLE_DEPTH-1], 1'b1));
    issue_command(scan_item(roster_uid[0], roster_len[0], 1'b0));
    issue_command(scan_item(random_uid(), 3'd6, 1'b1));
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_config_registers();
    test_enroll_cases();
    directed_count = commands_sent;

    test_random_traffic(200, '0, 3'd1, 16'd1);
    test_random_traffic(150, '1, 3'd7, 16'hFFFF);
    test_random_traffic(250, random_uid(), LEN_W'($urandom_range(1, 7)),
                        TICKS_W'($urandom_range(2, 12)));
    test_fill_table();
    test_random_traffic(250, random_uid(), LEN_W'($urandom_range(1, 7)),
                        TICKS_W'($urandom_range(1, 6)));

    // Drain, then watch for stray results
    wait_for_quiet();
    repeat (80) @(posedge clk);

    $display("%0d transactions (%0d directed), %0d results checked, table at %0d of %0d",
             commands_sent, directed_count, results_checked, roster_fill, TABLE_DEPTH);
    $display("arms %0d, adds %0d, refused %0d, grants %0d, denials %0d, closes %0d",
             event_tally[EV_ARMED], event_tally[EV_ADDED], event_tally[EV_NO_ADD],
             event_tally[EV_GRANTED], event_tally[EV_DENIED], event_tally[EV_CLOSED]);
    if (fail_count == 0) begin
      $display("card_access_whitelist_with_enroll_tb: PASS");
    end else begin
      $display("card_access_whitelist_with_enroll_tb: FAIL");
    end
    $finish;
  end

endmodule
